// ===== src/pbb_pkg.sv =====
package pbb_pkg;

  // fixed field widths
  localparam int CoordW = 32;
  localparam int ExtentW = 31;

  // queue between front and back
  localparam int CmdqDepth = 8;
  localparam int CmdqAw = $clog2(CmdqDepth);

  // result queue toward the receiver
  localparam int OutqDepth = 4;
  localparam int OutqAw = $clog2(OutqDepth);

  // stages from accept to the front's output register
  localparam int FrontStages = 4;

  typedef logic signed [CoordW-1:0] coord_t;

  // path command codes
  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_CURVE = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_NONE  = 3'd4
  } pbb_kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_A        = 3'd0,
    REG_COEF_B        = 3'd1,
    REG_COEF_C        = 3'd2,
    REG_COEF_D        = 3'd3,
    REG_SHIFT_E       = 3'd4,
    REG_SHIFT_F       = 3'd5,
    REG_STROKE_MODE   = 3'd6,
    REG_STROKE_EXTENT = 3'd7
  } pbb_reg_t;

  // stroke modes
  localparam logic [1:0] MODE_FILL = 2'd0;
  localparam logic [1:0] MODE_STROKE = 2'd1;

  // what the back end does with one command
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_HOLD  = 2'd1,
    OP_ADD   = 2'd2,
    OP_FLUSH = 2'd3
  } pbb_op_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
    coord_t e;
    coord_t f;
  } pbb_matrix_t;

  typedef struct packed {
    coord_t xmin;
    coord_t ymin;
    coord_t xmax;
    coord_t ymax;
  } pbb_box_t;

  typedef struct packed {
    pbb_op_t op;
    logic last;
    logic widen;
  } pbb_ctl_t;

  // one classified command, points already transformed and reduced to a box
  typedef struct packed {
    pbb_ctl_t ctl;
    pbb_box_t box;
  } pbb_item_t;

  typedef struct packed {
    pbb_box_t box;
    logic is_empty;
  } pbb_result_t;

endpackage

// ===== src/pbb_xform.sv =====
module pbb_xform import pbb_pkg::*; (
  input  logic        clk,
  input  coord_t      x,
  input  coord_t      y,
  input  pbb_matrix_t m,
  output coord_t      nx,
  output coord_t      ny
);

  logic signed [2*CoordW-1:0] prod_a, prod_b, prod_c, prod_d;
  logic signed [2*CoordW:0] sum_x, sum_y;

  // floor shift by 16, add translation, clamp to 32 bits
  function automatic coord_t shift_add_sat(logic signed [2*CoordW:0] s, coord_t t);
    logic signed [CoordW+17:0] v;
    coord_t r;
    v = (CoordW+18)'(s >>> 16) + (CoordW+18)'(t);
    if (!v[CoordW+17] && (v[CoordW+16:CoordW-1] != '0)) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v[CoordW+17] && (v[CoordW+16:CoordW-1] != '1)) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  // stage 1: products
  always_ff @(posedge clk) begin
    prod_a <= x * m.a;
    prod_c <= y * m.c;
    prod_b <= x * m.b;
    prod_d <= y * m.d;
  end

  // stage 2: exact product sums
  always_ff @(posedge clk) begin
    sum_x <= (2*CoordW+1)'(prod_a) + (2*CoordW+1)'(prod_c);
    sum_y <= (2*CoordW+1)'(prod_b) + (2*CoordW+1)'(prod_d);
  end

  // stage 3: scale, translate, saturate
  always_ff @(posedge clk) begin
    nx <= shift_add_sat(sum_x, m.e);
    ny <= shift_add_sat(sum_y, m.f);
  end

endmodule

// ===== src/pbb_front.sv =====
module pbb_front import pbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        kind,
  input  coord_t            px1,
  input  coord_t            py1,
  input  coord_t            px2,
  input  coord_t            py2,
  input  coord_t            px3,
  input  coord_t            py3,
  input  logic              last,
  input  pbb_matrix_t       m,
  input  logic [1:0]        mode,
  input  logic [CmdqAw:0]   q_level,
  output logic              item_valid,
  output pbb_item_t         item
);

  logic accept;
  logic skip;
  logic in_lead;
  logic is_curve;
  logic ends_lead;
  pbb_op_t op_in;
  logic [FrontStages-1:0] v;
  pbb_ctl_t ctl_q [FrontStages-1];
  logic [CmdqAw+1:0] level;
  coord_t qx1, qy1, qx2, qy2;
  coord_t nx0, ny0, nx1, ny1, nx2, ny2;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t r;
    r = (b < a) ? b : a;
    r = (c < r) ? c : r;
    return r;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t r;
    r = (b > a) ? b : a;
    r = (c > r) ? c : r;
    return r;
  endfunction

  // credit check: queue fill plus everything still in the pipeline
  assign level = (CmdqAw+2)'(q_level) + (CmdqAw+2)'(v[0]) + (CmdqAw+2)'(v[1])
               + (CmdqAw+2)'(v[2]) + (CmdqAw+2)'(v[3]);
  assign full = level >= (CmdqAw+2)'(CmdqDepth);
  assign accept = push && !full;

  assign skip = (mode == MODE_FILL) || (mode == MODE_STROKE);

  // classify the command
  always_comb begin
    op_in = OP_NONE;
    is_curve = 1'b0;
    ends_lead = 1'b0;
    unique case (kind)
      KIND_MOVE: begin
        op_in = (skip && in_lead) ? OP_HOLD : OP_ADD;
      end
      KIND_LINE: begin
        op_in = OP_ADD;
        ends_lead = 1'b1;
      end
      KIND_CURVE: begin
        op_in = OP_ADD;
        is_curve = 1'b1;
        ends_lead = 1'b1;
      end
      KIND_CLOSE: begin
        op_in = OP_FLUSH;
        ends_lead = 1'b1;
      end
      default: begin
        op_in = OP_NONE;
      end
    endcase
  end

  // non-curve commands feed the first point to all three transforms
  assign qx1 = is_curve ? px2 : px1;
  assign qy1 = is_curve ? py2 : py1;
  assign qx2 = is_curve ? px3 : px1;
  assign qy2 = is_curve ? py3 : py1;

  pbb_xform u_xf0 (.clk(clk), .x(px1), .y(py1), .m(m), .nx(nx0), .ny(ny0));
  pbb_xform u_xf1 (.clk(clk), .x(qx1), .y(qy1), .m(m), .nx(nx1), .ny(ny1));
  pbb_xform u_xf2 (.clk(clk), .x(qx2), .y(qy2), .m(m), .nx(nx2), .ny(ny2));

  // leading-move tracking and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      in_lead <= 1'b1;
    end else begin
      v <= {v[FrontStages-2:0], accept};
      if (accept) begin
        if (last) begin
          in_lead <= 1'b1;
        end else if (ends_lead) begin
          in_lead <= 1'b0;
        end
      end
    end
  end

  // control rides along with the transform pipeline
  always_ff @(posedge clk) begin
    ctl_q[0] <= '{op: op_in, last: last, widen: (mode != MODE_FILL)};
    for (int i = 1; i < FrontStages-1; i++) begin
      ctl_q[i] <= ctl_q[i-1];
    end
  end

  // stage 4: reduce the command's points to one box
  always_ff @(posedge clk) begin
    item.ctl <= ctl_q[FrontStages-2];
    item.box.xmin <= min3(nx0, nx1, nx2);
    item.box.ymin <= min3(ny0, ny1, ny2);
    item.box.xmax <= max3(nx0, nx1, nx2);
    item.box.ymax <= max3(ny0, ny1, ny2);
  end

  assign item_valid = v[FrontStages-1];

endmodule

// ===== src/pbb_cmdq.sv =====
module pbb_cmdq import pbb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  pbb_item_t       din,
  input  logic            rd_en,
  output pbb_item_t       dout,
  output logic            has_data,
  output logic [CmdqAw:0] count
);

  pbb_item_t entries [CmdqDepth];
  logic [CmdqAw-1:0] wr_ptr, rd_ptr;

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout = entries[rd_ptr];
  assign has_data = count != '0;

endmodule

// ===== src/pbb_back.sv =====
module pbb_back import pbb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pbb_item_t          head,
  input  logic               head_valid,
  output logic               take,
  input  logic [ExtentW-1:0] extent,
  output logic               empty,
  input  logic               pop,
  output pbb_result_t        result
);

  pbb_box_t run;
  logic started;
  coord_t pend_x, pend_y;
  logic pend_valid;
  logic use_pend, use_item;
  pbb_box_t pend_box, m1, m2;
  logic m1v, m2v;

  logic r_valid;
  logic r_widen;
  pbb_result_t r_res;
  pbb_result_t w_res;
  logic [CoordW-1:0] half;

  pbb_result_t outq [OutqDepth];
  logic [OutqAw-1:0] oq_wr, oq_rd;
  logic [OutqAw:0] oq_count;
  logic [OutqAw+1:0] oq_level;
  logic oq_pop;

  function automatic pbb_box_t merge_box(pbb_box_t a, logic va, pbb_box_t b, logic vb);
    pbb_box_t r;
    r = a;
    if (!va) begin
      r = b;
    end else if (vb) begin
      if (b.xmin < a.xmin) r.xmin = b.xmin;
      if (b.ymin < a.ymin) r.ymin = b.ymin;
      if (b.xmax > a.xmax) r.xmax = b.xmax;
      if (b.ymax > a.ymax) r.ymax = b.ymax;
    end
    return r;
  endfunction

  // 33-bit edge after widening, clamped to 32 bits
  function automatic coord_t sat_edge(logic [CoordW:0] v);
    coord_t r;
    unique case (v[CoordW:CoordW-1])
      2'b01:   r = {1'b0, {(CoordW-1){1'b1}}};
      2'b10:   r = {1'b1, {(CoordW-1){1'b0}}};
      default: r = v[CoordW-1:0];
    endcase
    return r;
  endfunction

  // room for a result: queue fill plus the widening stage
  assign oq_level = (OutqAw+2)'(oq_count) + (OutqAw+2)'(r_valid);
  assign take = head_valid && (!head.ctl.last || (oq_level < (OutqAw+2)'(OutqDepth)));

  // merge held move and command box into the running box
  assign use_pend = pend_valid && ((head.ctl.op == OP_ADD) || (head.ctl.op == OP_FLUSH));
  assign use_item = head.ctl.op == OP_ADD;
  assign pend_box = '{xmin: pend_x, ymin: pend_y, xmax: pend_x, ymax: pend_y};

  always_comb begin
    m1 = merge_box(run, started, pend_box, use_pend);
    m1v = started || use_pend;
    m2 = merge_box(m1, m1v, head.box, use_item);
    m2v = m1v || use_item;
  end

  // running path state
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pend_valid <= 1'b0;
    end else if (take) begin
      if (head.ctl.last) begin
        started <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        started <= m2v;
        if (head.ctl.op == OP_HOLD) begin
          pend_valid <= 1'b1;
        end else if (use_pend) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run <= m2;
      if (head.ctl.op == OP_HOLD) begin
        pend_x <= head.box.xmin;
        pend_y <= head.box.ymin;
      end
    end
  end

  // finished box register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= take && head.ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && head.ctl.last) begin
      r_res.box <= m2v ? m2 : '0;
      r_res.is_empty <= !m2v;
      r_widen <= head.ctl.widen && m2v;
    end
  end

  // widen by half the stroke extent when stroking
  assign half = {2'b00, extent[ExtentW-1:1]};

  always_comb begin
    w_res = r_res;
    if (r_widen) begin
      w_res.box.xmin = sat_edge({r_res.box.xmin[CoordW-1], r_res.box.xmin} - {1'b0, half});
      w_res.box.ymin = sat_edge({r_res.box.ymin[CoordW-1], r_res.box.ymin} - {1'b0, half});
      w_res.box.xmax = sat_edge({r_res.box.xmax[CoordW-1], r_res.box.xmax} + {1'b0, half});
      w_res.box.ymax = sat_edge({r_res.box.ymax[CoordW-1], r_res.box.ymax} + {1'b0, half});
    end
  end

  // result queue
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (r_valid) begin
      outq[oq_wr] <= w_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr <= '0;
      oq_rd <= '0;
      oq_count <= '0;
    end else begin
      if (r_valid) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (r_valid && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (!r_valid && oq_pop) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  assign empty = oq_count == '0;
  assign result = outq[oq_rd];

endmodule

// ===== src/path_bounding_box.sv =====
// Bounding box of an affine-transformed path, one path command per transaction.
// Command side is a queue: a command is taken at a clock edge with push high and
// full low. kind selects move, line, curve, close or no command; px1..py3 carry
// the control points and last closes the path.
// Result side is a queue: while empty is low the oldest box sits on box_xmin..
// box_ymax and is_empty, and pop high at a clock edge takes it. One result per path.
// Configuration writes use cfg_valid/cfg_ready (ready is always high) with
// cfg_index selecting the register; write only while no path is in flight.
// Throughput: one command per cycle while full is low, curves included (three point
// transforms run side by side). A last command's box shows with empty low once it
// has passed the four front stages (multiply, sum, scale and clamp, point reduce),
// the command queue, the box merge and the widening stage.
// full rises when eight commands sit in the four front stages and the
// eight-entry command queue together.
// Reset restores the identity matrix, fill mode, zero extent, and empties both
// queues and all path state.
// When the receiver stalls, up to four boxes wait in the result queue; after
// that the back end holds the next last command, the command queue fills and
// full goes high.
module path_bounding_box import pbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind,
  input  coord_t      px1,
  input  coord_t      py1,
  input  coord_t      px2,
  input  coord_t      py2,
  input  coord_t      px3,
  input  coord_t      py3,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output coord_t      box_xmin,
  output coord_t      box_ymin,
  output coord_t      box_xmax,
  output coord_t      box_ymax,
  output logic        is_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pbb_matrix_t m;
  logic [1:0] stroke_mode;
  logic [ExtentW-1:0] stroke_extent;

  logic q_push, q_pop, q_has_data;
  pbb_item_t q_din, q_dout;
  logic [CmdqAw:0] q_count;
  pbb_result_t result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m.a <= coord_t'(32'sd65536);
      m.b <= '0;
      m.c <= '0;
      m.d <= coord_t'(32'sd65536);
      m.e <= '0;
      m.f <= '0;
      stroke_mode <= MODE_FILL;
      stroke_extent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COEF_A:        m.a <= cfg_data;
        REG_COEF_B:        m.b <= cfg_data;
        REG_COEF_C:        m.c <= cfg_data;
        REG_COEF_D:        m.d <= cfg_data;
        REG_SHIFT_E:       m.e <= cfg_data;
        REG_SHIFT_F:       m.f <= cfg_data;
        REG_STROKE_MODE:   stroke_mode <= cfg_data[1:0];
        REG_STROKE_EXTENT: stroke_extent <= cfg_data[ExtentW-1:0];
        default:           stroke_mode <= stroke_mode;
      endcase
    end
  end

  pbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .px1        (px1),
    .py1        (py1),
    .px2        (px2),
    .py2        (py2),
    .px3        (px3),
    .py3        (py3),
    .last       (last),
    .m          (m),
    .mode       (stroke_mode),
    .q_level    (q_count),
    .item_valid (q_push),
    .item       (q_din)
  );

  pbb_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .din      (q_din),
    .rd_en    (q_pop),
    .dout     (q_dout),
    .has_data (q_has_data),
    .count    (q_count)
  );

  pbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_dout),
    .head_valid (q_has_data),
    .take       (q_pop),
    .extent     (stroke_extent),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  assign box_xmin = result.box.xmin;
  assign box_ymin = result.box.ymin;
  assign box_xmax = result.box.xmax;
  assign box_ymax = result.box.ymax;
  assign is_empty = result.is_empty;

`ifndef SYNTH
  // front credit check never lets the command queue overflow
  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |-> q_count < (CmdqAw+1)'(CmdqDepth))
    else $error("command queue overflow");

  // back end only takes from a queue that holds something
  a_cmdq_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("command queue underflow");

  // after reset nothing is pending and commands are taken
  a_reset_clean: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("state not clean after reset");
`endif

endmodule
